// ===== design/favtp_pkg.sv =====
// Shared types and codes for the FLV AVC video tag parser.
// No dependencies.
package favtp_pkg;

    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_CONFIG  = 3'd1;
    localparam logic [2:0] EV_SPS     = 3'd2;
    localparam logic [2:0] EV_PPS     = 3'd3;
    localparam logic [2:0] EV_NAL     = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;
    localparam logic [2:0] EV_END     = 3'd6;

    localparam logic [2:0] ERR_CODEC     = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_SPS_COUNT = 3'd2;
    localparam logic [2:0] ERR_PPS_COUNT = 3'd3;
    localparam logic [2:0] ERR_SLICE     = 3'd4;

    localparam logic [3:0] CODEC_AVC   = 4'd7;
    localparam logic [4:0] NAL_SLICE   = 5'd1;
    localparam logic [4:0] NAL_IDR     = 5'd5;
    localparam logic [7:0] PKT_CONFIG  = 8'd0;
    localparam logic [7:0] PKT_NALU    = 8'd1;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  frame_type;
        logic [7:0]  packet_type;
        logic [23:0] composition_time;
        logic [7:0]  profile;
        logic [7:0]  compatibility;
        logic [7:0]  level;
        logic [2:0]  length_size;
        logic [7:0]  payload_byte;
        logic [31:0] length_value;
        logic [4:0]  nal_type;
        logic [2:0]  error_code;
    } favtp_result_t;

    // One entry per accepted byte: an optional event, then an optional end_of_tag.
    typedef struct packed {
        logic          has_event;
        logic          has_end;
        favtp_result_t res;
    } favtp_item_t;

endpackage

// ===== design/favtp_core.sv =====
// Byte-serial parse state and event decode for the FLV AVC video tag parser.
// Depends on favtp_pkg.
module favtp_core #(
    parameter int NAL_LENGTH_BYTES = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output favtp_pkg::favtp_item_t item
);
    import favtp_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_CFG, PH_SPS_LEN, PH_SPS, PH_PPS_CNT, PH_PPS_LEN, PH_PPS,
        PH_CFG_END, PH_NAL_LEN, PH_NAL_HDR, PH_NAL_BODY, PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] fc_reg, fc_next;
    logic [3:0]  ft_reg, ft_next;
    logic [7:0]  pt_reg, pt_next;
    logic [23:0] time_reg, time_next;
    logic [23:0] prof_reg, prof_next;
    logic [1:0]  lsz_reg, lsz_next;
    logic [15:0] sps_len_reg, sps_len_next;
    logic [15:0] pps_len_reg, pps_len_next;
    logic [31:0] nal_rem_reg, nal_rem_next;
    logic        slice_pend_reg, slice_pend_next;

    logic [15:0] fc_inc;
    logic [31:0] nal_dec;

    assign fc_inc  = fc_reg + 16'd1;
    assign nal_dec = nal_rem_reg - 32'd1;

    always_comb begin
        phase_next      = phase_reg;
        fc_next         = fc_reg;
        ft_next         = ft_reg;
        pt_next         = pt_reg;
        time_next       = time_reg;
        prof_next       = prof_reg;
        lsz_next        = lsz_reg;
        sps_len_next    = sps_len_reg;
        pps_len_next    = pps_len_reg;
        nal_rem_next    = nal_rem_reg;
        slice_pend_next = slice_pend_reg;
        item            = '0;
        item.has_end    = in_last;

        unique case (phase_reg)
            PH_HDR: begin
                if (fc_reg == 16'd0) begin
                    ft_next = in_byte[7:4];
                    if (in_byte[3:0] != CODEC_AVC) begin
                        item.has_event      = 1'b1;
                        item.res.event_res  = EV_ERROR;
                        item.res.error_code = ERR_CODEC;
                        phase_next          = PH_SKIP;
                    end else begin
                        fc_next = 16'd1;
                    end
                end else if (fc_reg == 16'd1) begin
                    pt_next = in_byte;
                    fc_next = 16'd2;
                end else begin
                    time_next = {time_reg[15:0], in_byte};
                    if (fc_reg >= 16'd4) begin
                        item.has_event            = 1'b1;
                        item.res.event_res        = EV_HEADER;
                        item.res.frame_type       = ft_reg;
                        item.res.packet_type      = pt_reg;
                        item.res.composition_time = {time_reg[15:0], in_byte};
                        fc_next                   = 16'd0;
                        if (pt_reg == PKT_CONFIG) begin
                            phase_next = PH_CFG;
                        end else if (pt_reg == PKT_NALU) begin
                            phase_next = PH_NAL_LEN;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        fc_next = fc_inc;
                    end
                end
            end
            PH_CFG: begin
                if (fc_reg == 16'd0) begin
                    if (in_byte != 8'd1) begin
                        item.has_event      = 1'b1;
                        item.res.event_res  = EV_ERROR;
                        item.res.error_code = ERR_VERSION;
                        phase_next          = PH_SKIP;
                    end else begin
                        fc_next = fc_inc;
                    end
                end else if (fc_reg <= 16'd3) begin
                    prof_next = {prof_reg[15:0], in_byte};
                    fc_next   = fc_inc;
                end else if (fc_reg == 16'd4) begin
                    lsz_next = in_byte[1:0];
                    fc_next  = fc_inc;
                end else if (in_byte[4:0] != 5'd1) begin
                    item.has_event      = 1'b1;
                    item.res.event_res  = EV_ERROR;
                    item.res.error_code = ERR_SPS_COUNT;
                    phase_next          = PH_SKIP;
                end else begin
                    item.has_event         = 1'b1;
                    item.res.event_res     = EV_CONFIG;
                    item.res.profile       = prof_reg[23:16];
                    item.res.compatibility = prof_reg[15:8];
                    item.res.level         = prof_reg[7:0];
                    item.res.length_size   = {1'b0, lsz_reg} + 3'd1;
                    fc_next                = 16'd0;
                    phase_next             = PH_SPS_LEN;
                end
            end
            PH_SPS_LEN: begin
                sps_len_next = {sps_len_reg[7:0], in_byte};
                if (fc_reg >= 16'd1) begin
                    fc_next    = 16'd0;
                    phase_next = ({sps_len_reg[7:0], in_byte} != 16'd0) ? PH_SPS : PH_PPS_CNT;
                end else begin
                    fc_next = 16'd1;
                end
            end
            PH_SPS: begin
                item.has_event            = 1'b1;
                item.res.event_res        = EV_SPS;
                item.res.payload_byte     = in_byte;
                item.res.length_value     = {16'd0, sps_len_reg};
                fc_next                   = fc_inc;
                if (fc_inc >= sps_len_reg) begin
                    fc_next    = 16'd0;
                    phase_next = PH_PPS_CNT;
                end
            end
            PH_PPS_CNT: begin
                if (in_byte != 8'd1) begin
                    item.has_event      = 1'b1;
                    item.res.event_res  = EV_ERROR;
                    item.res.error_code = ERR_PPS_COUNT;
                    phase_next          = PH_SKIP;
                end else begin
                    fc_next    = 16'd0;
                    phase_next = PH_PPS_LEN;
                end
            end
            PH_PPS_LEN: begin
                pps_len_next = {pps_len_reg[7:0], in_byte};
                if (fc_reg >= 16'd1) begin
                    fc_next    = 16'd0;
                    phase_next = ({pps_len_reg[7:0], in_byte} != 16'd0) ? PH_PPS : PH_CFG_END;
                end else begin
                    fc_next = 16'd1;
                end
            end
            PH_PPS: begin
                item.has_event            = 1'b1;
                item.res.event_res        = EV_PPS;
                item.res.payload_byte     = in_byte;
                item.res.length_value     = {16'd0, pps_len_reg};
                fc_next                   = fc_inc;
                if (fc_inc >= pps_len_reg) begin
                    fc_next    = 16'd0;
                    phase_next = PH_CFG_END;
                end
            end
            PH_NAL_LEN: begin
                nal_rem_next = {nal_rem_reg[23:0], in_byte};
                fc_next      = fc_inc;
                if (fc_inc >= 16'(NAL_LENGTH_BYTES)) begin
                    fc_next = 16'd0;
                    if ({nal_rem_reg[23:0], in_byte} == 32'd0) begin
                        item.has_event     = 1'b1;
                        item.res.event_res = EV_NAL;
                    end else begin
                        phase_next = PH_NAL_HDR;
                    end
                end
            end
            PH_NAL_HDR: begin
                item.has_event        = 1'b1;
                item.res.event_res    = EV_NAL;
                item.res.length_value = nal_rem_reg;
                item.res.nal_type     = in_byte[4:0];
                nal_rem_next          = nal_dec;
                if (nal_dec == 32'd0) begin
                    phase_next = PH_NAL_LEN;
                end else begin
                    slice_pend_next = (in_byte[4:0] == NAL_SLICE) ||
                                      (in_byte[4:0] == NAL_IDR);
                    phase_next      = PH_NAL_BODY;
                end
            end
            PH_NAL_BODY: begin
                if (slice_pend_reg && !in_byte[7]) begin
                    slice_pend_next     = 1'b0;
                    item.has_event      = 1'b1;
                    item.res.event_res  = EV_ERROR;
                    item.res.error_code = ERR_SLICE;
                    phase_next          = PH_SKIP;
                end else begin
                    slice_pend_next = 1'b0;
                    nal_rem_next    = nal_dec;
                    if (nal_dec == 32'd0) begin
                        phase_next = PH_NAL_LEN;
                    end
                end
            end
            PH_CFG_END, PH_SKIP: begin
            end
            default: begin
            end
        endcase

        if (in_last) begin
            phase_next      = PH_HDR;
            fc_next         = '0;
            ft_next         = '0;
            pt_next         = '0;
            time_next       = '0;
            prof_next       = '0;
            lsz_next        = '0;
            sps_len_next    = '0;
            pps_len_next    = '0;
            nal_rem_next    = '0;
            slice_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR;
            fc_reg         <= '0;
            ft_reg         <= '0;
            pt_reg         <= '0;
            time_reg       <= '0;
            prof_reg       <= '0;
            lsz_reg        <= '0;
            sps_len_reg    <= '0;
            pps_len_reg    <= '0;
            nal_rem_reg    <= '0;
            slice_pend_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg      <= phase_next;
            fc_reg         <= fc_next;
            ft_reg         <= ft_next;
            pt_reg         <= pt_next;
            time_reg       <= time_next;
            prof_reg       <= prof_next;
            lsz_reg        <= lsz_next;
            sps_len_reg    <= sps_len_next;
            pps_len_reg    <= pps_len_next;
            nal_rem_reg    <= nal_rem_next;
            slice_pend_reg <= slice_pend_next;
        end
    end

endmodule

// ===== design/flv_avc_video_tag_parser.sv =====
// Top level of the FLV AVC video tag parser: byte input, event output queue.
// Depends on favtp_pkg and favtp_core.
//
// Input: one payload byte of an FLV video tag per transfer on s_axis, with
// s_axis_tlast on the final byte of the tag. Output: one event per transfer
// on m_axis; m_axis_tuser carries the event kind, m_axis_tdata the fields.
// Each byte is decoded in the cycle it is accepted and its event, if any,
// is written to a two-entry result queue, from which it is offered on m_axis
// once the entries ahead of it have left. One byte is taken every cycle while
// the queue is not full. The last byte of a tag may yield two events (its
// own event then end_of_tag); both sit in one queue entry and leave as two
// separate output transfers, so that byte costs one extra transfer.
// Fields that do not belong to an event read as zero.
// Reset clears the parse state and empties the queue. When m_axis_tready is
// low the queue fills and s_axis_tready drops after two pending entries;
// nothing is lost.
module flv_avc_video_tag_parser #(
    parameter int NAL_LENGTH_BYTES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] frame_type, [11:4] packet_type, [35:12] composition_time,
    // [43:36] profile, [51:44] compatibility, [59:52] level,
    // [62:60] length_size, [70:63] payload_byte, [102:71] length_value,
    // [107:103] nal_type, [110:108] error_code, [111] zero
    output logic [111:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // [2:0] event_res
);
    import favtp_pkg::*;

    favtp_item_t   item;
    favtp_item_t   q_mem [2];
    favtp_item_t   head;
    favtp_result_t out_res;
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          sub_reg;
    logic          s_acc, m_acc, push, pop;
    logic          has_item;

    assign s_axis_tready = (count_reg != 2'd2);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    favtp_core #(
        .NAL_LENGTH_BYTES(NAL_LENGTH_BYTES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_accept(s_acc),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .item     (item)
    );

    assign has_item = item.has_event || item.has_end;
    assign push     = s_acc && has_item;

    assign head          = q_mem[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_acc         = m_axis_tvalid && m_axis_tready;
    // an entry with both parts leaves after its second transfer
    assign pop           = m_acc && (!head.has_event || !head.has_end || sub_reg);

    always_comb begin
        if (head.has_event && !sub_reg) begin
            out_res = head.res;
        end else begin
            out_res           = '0;
            out_res.event_res = EV_END;
        end
    end

    assign m_axis_tuser = out_res.event_res;
    assign m_axis_tdata = {1'b0, out_res.error_code, out_res.nal_type,
                           out_res.length_value, out_res.payload_byte,
                           out_res.length_size, out_res.level, out_res.compatibility,
                           out_res.profile, out_res.composition_time,
                           out_res.packet_type, out_res.frame_type};

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (m_acc) begin
                sub_reg <= 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_second_part_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && sub_reg |-> m_axis_tuser == EV_END)
        else $error("second part of an entry is not end_of_tag");

    a_last_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_axis_tlast |=> m_axis_tvalid)
        else $error("last byte left no result");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not follow a write");

    a_sub_only_split: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> head.has_event && head.has_end && m_axis_tvalid)
        else $error("split transfer flag set on a single-part entry");

endmodule
